### hw/rtl/bsm_pkg.sv
// Package for the bounding sphere merge core: widths and shared types.
// No dependencies.
package bsm_pkg;
    localparam int CW = 32;               // coordinate / radius width
    localparam int DW = CW + 1;           // centre difference magnitude width
    localparam int SW = 2 * DW + 2;       // sum of squares width
    localparam int QW = DW + 1;           // sqrt result width
    localparam int PW = DW + QW + 1;      // offset product width

    typedef logic signed [CW-1:0] t_coord;
    typedef logic        [CW-1:0] t_rad;

    // Operation select for the shared unit
    typedef enum logic [2:0] {
        OP_SQRT = 3'b001,
        OP_DIV  = 3'b010,
        OP_MUL  = 3'b100
    } t_op;

    // Control between sequencer and shared unit
    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_ctl;

    typedef struct packed {
        logic done;
    } t_unit_sts;
endpackage

### hw/rtl/bsm_if.sv
// Valid/ready channel interfaces for the bounding sphere merge core.
// Depends on bsm_pkg.
interface bsm_in_if;
    logic             valid;
    logic             ready;
    bsm_pkg::t_coord  center_x;
    bsm_pkg::t_coord  center_y;
    bsm_pkg::t_coord  center_z;
    bsm_pkg::t_rad    radius;
    logic             last_sphere;
    modport source (output valid, center_x, center_y, center_z, radius, last_sphere,
                    input ready);
    modport sink   (input valid, center_x, center_y, center_z, radius, last_sphere,
                    output ready);
endinterface

interface bsm_out_if;
    logic                       valid;
    logic                       ready;
    bsm_pkg::t_coord            out_center_x;
    bsm_pkg::t_coord            out_center_y;
    bsm_pkg::t_coord            out_center_z;
    logic [bsm_pkg::CW:0]       out_radius_doubled;
    modport source (output valid, out_center_x, out_center_y, out_center_z,
                    out_radius_doubled, input ready);
    modport sink   (input valid, out_center_x, out_center_y, out_center_z,
                    out_radius_doubled, output ready);
endinterface

### hw/rtl/bsm_unit.sv
// Shared iterative arithmetic unit: restoring sqrt, restoring divide,
// shift-add multiply, one bit per cycle. Depends on bsm_pkg.
module bsm_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bsm_pkg::t_unit_ctl       i_ctl,
    input  logic [bsm_pkg::PW-1:0]   i_a,     // sqrt radicand / dividend / multiplicand
    input  logic [bsm_pkg::PW-1:0]   i_b,     // divisor / multiplier
    output bsm_pkg::t_unit_sts       o_sts,
    output logic [bsm_pkg::PW-1:0]   o_res
);
    localparam int PW = bsm_pkg::PW;
    localparam int CNTW = $clog2(PW + 1);

    bsm_pkg::t_op     r_op;
    logic             r_busy, r_done;
    logic [CNTW-1:0]  r_cnt;
    logic [PW-1:0]    r_a, r_b, r_acc, r_rem, r_q;

    logic [PW+1:0]    w_rem2, w_trial;
    logic [PW-1:0]    w_mulsum;

    // sqrt: two radicand bits into remainder; trial = 4q+1
    // div: one dividend bit into remainder; trial = divisor
    always_comb begin
        w_rem2   = '0;
        w_trial  = '0;
        w_mulsum = r_acc + r_a;
        unique case (r_op)
            bsm_pkg::OP_SQRT: begin
                w_rem2  = {r_rem, r_a[PW-1:PW-2]};
                w_trial = {r_q, 2'b01};
            end
            bsm_pkg::OP_DIV: begin
                w_rem2  = {1'b0, r_rem, r_a[PW-1]};
                w_trial = {2'b00, r_b};
            end
            default: begin
                w_rem2  = '0;
                w_trial = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= bsm_pkg::OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_op   <= i_ctl.op;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= (i_ctl.op == bsm_pkg::OP_SQRT) ? CNTW'(PW / 2) : CNTW'(PW);
            end else if (r_busy) begin
                unique case (r_op)
                    bsm_pkg::OP_SQRT: begin
                        r_a <= {r_a[PW-3:0], 2'b00};
                        if (w_rem2 >= w_trial) begin
                            r_rem <= PW'(w_rem2 - w_trial);
                            r_q   <= {r_q[PW-2:0], 1'b1};
                        end else begin
                            r_rem <= PW'(w_rem2);
                            r_q   <= {r_q[PW-2:0], 1'b0};
                        end
                    end
                    bsm_pkg::OP_DIV: begin
                        r_a <= {r_a[PW-2:0], 1'b0};
                        if (w_rem2 >= w_trial) begin
                            r_rem <= PW'(w_rem2 - w_trial);
                            r_q   <= {r_q[PW-2:0], 1'b1};
                        end else begin
                            r_rem <= PW'(w_rem2);
                            r_q   <= {r_q[PW-2:0], 1'b0};
                        end
                    end
                    default: begin
                        if (r_b[0]) r_acc <= w_mulsum;
                        r_a <= {r_a[PW-2:0], 1'b0};
                        r_b <= {1'b0, r_b[PW-1:1]};
                    end
                endcase
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_res = (r_op == bsm_pkg::OP_MUL) ? r_acc : r_q;
endmodule

### hw/rtl/bounding_sphere_merge_core.sv
// Top level of the bounding sphere merge core: sequencer and sphere store.
// Depends on bsm_pkg, bsm_if and bsm_unit.
//
//  channel   dir  handshake     payload
//  i_sph     in   valid/ready   center_x/y/z, radius, last_sphere
//  o_res     out  valid/ready   out_center_x/y/z, out_radius_doubled
//
// A sphere that starts a run becomes the held sphere and passes through S_EMIT. A folded
// sphere runs three squares and a square root on the shared unit, which is all it needs
// when it lies inside or contains the held sphere. A merge adds per axis a multiply and
// a divide on the same shared unit, which is bit-serial (one bit per cycle).
// A last sphere then passes through S_OUT, which loads the result register once it is free.
// Synchronous active-low reset clears the store and the sequencer.
// A result waits in the output register while input goes on; the next result
// holds the sequencer until the first is taken.
module bounding_sphere_merge_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bsm_in_if.sink           i_sph,
    bsm_out_if.source        o_res
);
    localparam int CW = bsm_pkg::CW;
    localparam int DW = bsm_pkg::DW;
    localparam int PW = bsm_pkg::PW;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SQX   = 11'b00000000010,
        S_SQY   = 11'b00000000100,
        S_SQZ   = 11'b00000001000,
        S_SQRT  = 11'b00000010000,
        S_TEST  = 11'b00000100000,
        S_MUL   = 11'b00001000000,
        S_DIV   = 11'b00010000000,
        S_AXIS  = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state;
    logic   r_wait;           // shared unit running
    logic   r_have;
    logic [1:0] r_axis;
    logic signed [CW-1:0] r_ax, r_ay, r_az, r_nx, r_ny, r_nz;
    logic [CW-1:0]  r_ar, r_nr;
    logic           r_last;
    logic [PW-1:0]  r_sum, r_dist, r_t;
    logic           r_ovalid;
    logic signed [CW-1:0] r_ox, r_oy, r_oz;
    logic [CW:0]    r_ord;

    bsm_pkg::t_unit_ctl w_ctl;
    bsm_pkg::t_unit_sts w_sts;
    logic [PW-1:0]      w_a, w_b, w_res;

    // Difference per axis selected by r_axis
    logic signed [CW:0] w_d;
    logic [DW-1:0]      w_ud;
    logic signed [CW-1:0] w_ac;
    always_comb begin
        unique case (r_axis)
            2'd0:    begin w_d = {r_nx[CW-1], r_nx} - {r_ax[CW-1], r_ax}; w_ac = r_ax; end
            2'd1:    begin w_d = {r_ny[CW-1], r_ny} - {r_ay[CW-1], r_ay}; w_ac = r_ay; end
            default: begin w_d = {r_nz[CW-1], r_nz} - {r_az[CW-1], r_az}; w_ac = r_az; end
        endcase
        w_ud = w_d[CW] ? DW'(-w_d) : DW'(w_d);
    end

    bsm_unit u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_sts  (w_sts),
        .o_res  (w_res)
    );

    // Unit operands and start per state
    always_comb begin
        w_ctl.start = 1'b0;
        w_ctl.op    = bsm_pkg::OP_MUL;
        w_a = PW'(w_ud);
        w_b = PW'(w_ud);
        unique case (r_state)
            S_SQX, S_SQY, S_SQZ: w_ctl.start = !r_wait;
            S_SQRT: begin
                w_ctl.start = !r_wait;
                w_ctl.op    = bsm_pkg::OP_SQRT;
                w_a         = r_sum;
            end
            S_MUL: begin
                w_ctl.start = !r_wait;
                w_b         = r_t;
            end
            S_DIV: begin
                w_ctl.start = !r_wait;
                w_ctl.op    = bsm_pkg::OP_DIV;
                w_a         = r_sum;
                w_b         = {r_dist[PW-2:0], 1'b0};
            end
            default: ;
        endcase
    end

    // Tests and merge radius
    logic [PW-1:0] w_dn, w_da, w_mr;
    logic signed [CW:0] w_c;
    assign w_dn = r_dist + PW'(r_nr);
    assign w_da = r_dist + PW'(r_ar);
    assign w_mr = (w_dn + PW'(r_ar)) >> 1;
    assign w_c  = w_d[CW] ? ({w_ac[CW-1], w_ac} - (CW+1)'(w_res))
                          : ({w_ac[CW-1], w_ac} + (CW+1)'(w_res));

    assign i_sph.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.out_center_x = r_ox;
    assign o_res.out_center_y = r_oy;
    assign o_res.out_center_z = r_oz;
    assign o_res.out_radius_doubled = r_ord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
            r_ax <= '0; r_ay <= '0; r_az <= '0; r_ar <= '0;
        end else begin
            if (o_res.valid && o_res.ready) r_ovalid <= 1'b0;
            if (w_ctl.start) r_wait <= 1'b1;
            if (w_sts.done)  r_wait <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_sph.valid && i_sph.ready) begin
                    r_nx <= i_sph.center_x; r_ny <= i_sph.center_y;
                    r_nz <= i_sph.center_z; r_nr <= i_sph.radius;
                    r_last <= i_sph.last_sphere;
                    r_axis <= 2'd0;
                    r_sum  <= '0;
                    if (!r_have) begin
                        r_ax <= i_sph.center_x; r_ay <= i_sph.center_y;
                        r_az <= i_sph.center_z; r_ar <= i_sph.radius;
                        r_have <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_SQX;
                    end
                end
                S_SQX, S_SQY, S_SQZ: if (w_sts.done) begin
                    r_sum  <= r_sum + w_res;
                    r_axis <= r_axis + 2'd1;
                    r_state <= (r_state == S_SQX) ? S_SQY :
                               (r_state == S_SQY) ? S_SQZ : S_SQRT;
                end
                S_SQRT: if (w_sts.done) begin
                    r_dist <= w_res;
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    r_axis <= 2'd0;
                    r_t    <= w_dn - PW'(r_ar);
                    if (w_dn <= PW'(r_ar)) begin
                        r_state <= S_EMIT;
                    end else if (w_da <= PW'(r_nr) || r_dist == '0) begin
                        r_ax <= r_nx; r_ay <= r_ny; r_az <= r_nz; r_ar <= r_nr;
                        r_state <= S_EMIT;
                    end else begin
                        r_ar <= (w_mr > PW'({CW{1'b1}})) ? {CW{1'b1}} : CW'(w_mr);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: if (w_sts.done) begin
                    r_sum   <= w_res;
                    r_state <= S_DIV;
                end
                S_DIV: if (w_sts.done) r_state <= S_AXIS;
                S_AXIS: begin
                    unique case (r_axis)
                        2'd0:    r_ax <= CW'(w_c);
                        2'd1:    r_ay <= CW'(w_c);
                        default: r_az <= CW'(w_c);
                    endcase
                    r_axis  <= r_axis + 2'd1;
                    r_state <= (r_axis == 2'd2) ? S_EMIT : S_MUL;
                end
                S_EMIT: r_state <= r_last ? S_OUT : S_IDLE;
                S_OUT: if (!r_ovalid) begin
                    r_ox <= r_ax; r_oy <= r_ay; r_oz <= r_az;
                    r_ord <= {r_ar, 1'b0};
                    r_ovalid <= 1'b1;
                    r_have <= 1'b0;
                    r_ax <= '0; r_ay <= '0; r_az <= '0; r_ar <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### bench/testbench.sv
// Testbench for bounding_sphere_merge_core: directed and random sphere runs,
// checked against an in-bench fixed-point predictor. Depends on bsm_pkg, bsm_if and the RTL.
`timescale 1ns / 1ps
module testbench;
    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [32:0] rd;
    } t_sphere_res;

    logic i_clk;
    logic i_rst_n;
    bsm_in_if  sph_if();
    bsm_out_if res_if();

    bounding_sphere_merge_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sph   (sph_if.sink),
        .o_res   (res_if.source)
    );

    // predictor state
    logic signed [31:0] hold_x, hold_y, hold_z;
    logic [31:0]        hold_r;
    logic               hold_valid;

    t_sphere_res expected_spheres[$];
    int          error_count;
    longint      cycle_count;
    int          hold_off_cycles;
    bit          rand_stall_en;

    localparam longint CYCLE_LIMIT = 64'd6000000;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bounding_sphere_merge_core verification failed");
            $finish;
        end
    end

    // integer square root, floor
    function automatic logic [63:0] isqrt(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= n) r = c;
        end
        return r;
    endfunction

    // centre step along one axis, offset truncated toward the old centre
    function automatic logic [31:0] step_axis(longint a, longint n, logic [63:0] t,
                                              logic [63:0] span);
        longint      d;
        logic [63:0] ad;
        logic [127:0] q;
        d  = n - a;
        ad = d < 0 ? -d : d;
        q  = (128'(ad) * 128'(t)) / 128'(span << 1);
        return d < 0 ? 32'(a - longint'(q[63:0])) : 32'(a + longint'(q[63:0]));
    endfunction

    task automatic fold_sphere(logic signed [31:0] nx, ny, nz, logic [31:0] nr);
        longint      ux, uy, uz;
        logic [127:0] s;
        logic [63:0] span, t, mr, ar;
        ux = longint'(nx) - longint'(hold_x); ux = ux < 0 ? -ux : ux;
        uy = longint'(ny) - longint'(hold_y); uy = uy < 0 ? -uy : uy;
        uz = longint'(nz) - longint'(hold_z); uz = uz < 0 ? -uz : uz;
        s = 128'(ux) * 128'(ux) + 128'(uy) * 128'(uy) + 128'(uz) * 128'(uz);
        span = isqrt(s);
        ar = 64'(hold_r);
        if (span + nr <= ar) return;
        if (span + ar <= nr || span == 0) begin
            hold_x = nx; hold_y = ny; hold_z = nz; hold_r = nr;
            return;
        end
        t = span + nr - ar;
        hold_x = step_axis(hold_x, nx, t, span);
        hold_y = step_axis(hold_y, ny, t, span);
        hold_z = step_axis(hold_z, nz, t, span);
        mr = (span + ar + nr) >> 1;
        hold_r = mr > 64'hffff_ffff ? 32'hffff_ffff : mr[31:0];
    endtask

    task automatic predict_union(logic [31:0] x, y, z, r, logic last);
        t_sphere_res e;
        if (!hold_valid) begin
            hold_x = x; hold_y = y; hold_z = z; hold_r = r; hold_valid = 1'b1;
        end else begin
            fold_sphere(x, y, z, r);
        end
        if (last) begin
            e.cx = hold_x; e.cy = hold_y; e.cz = hold_z; e.rd = {hold_r, 1'b0};
            expected_spheres.push_back(e);
            hold_x = '0; hold_y = '0; hold_z = '0; hold_r = '0; hold_valid = 1'b0;
        end
    endtask

    task automatic report_mismatch(string what, logic [32:0] got, logic [32:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // send one sphere transaction; valid stays up into a back-to-back follower
    task automatic send_sphere(logic [31:0] x, y, z, r, logic last, bit gap = 1);
        int idle;
        idle = gap ? $urandom_range(0, 11) : 0;
        if (idle > 0) begin
            sph_if.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        sph_if.valid       <= 1'b1;
        sph_if.center_x    <= x;
        sph_if.center_y    <= y;
        sph_if.center_z    <= z;
        sph_if.radius      <= r;
        sph_if.last_sphere <= last;
        @(posedge i_clk);
        while (!sph_if.ready) @(posedge i_clk);
        predict_union(x, y, z, r, last);
    endtask

    // result checker and receiver stall
    initial begin
        int wait_n;
        t_sphere_res e;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                res_if.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end
            wait_n = rand_stall_en ? $urandom_range(0, 11) : 0;
            if (wait_n > 0) begin
                res_if.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            if (expected_spheres.size() == 0) begin
                report_mismatch("unexpected result", res_if.out_radius_doubled, '0);
            end else begin
                e = expected_spheres.pop_front();
                if (res_if.out_center_x !== e.cx) report_mismatch("cx", res_if.out_center_x, e.cx);
                if (res_if.out_center_y !== e.cy) report_mismatch("cy", res_if.out_center_y, e.cy);
                if (res_if.out_center_z !== e.cz) report_mismatch("cz", res_if.out_center_z, e.cz);
                if (res_if.out_radius_doubled !== e.rd)
                    report_mismatch("radius", res_if.out_radius_doubled, e.rd);
            end
        end
    end

    task automatic drain_results();
        sph_if.valid <= 1'b0;
        while (expected_spheres.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            2: return $urandom_range(0, 4096);
            default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    task automatic test_directed();
        // single sphere runs at the field extremes
        send_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 1'b1);
        send_sphere(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0, 1'b1);
        // new sphere inside held one
        send_sphere(32'h0, 32'h0, 32'h0, 32'h0010_0000, 1'b0);
        send_sphere(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b1);
        // new sphere contains held one
        send_sphere(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b0);
        send_sphere(32'h0, 32'h0, 32'h0, 32'h0010_0000, 1'b1);
        // zero distance, equal and unequal radii
        send_sphere(32'h1234_0000, 32'h5, 32'hffff_0000, 32'h100, 1'b0);
        send_sphere(32'h1234_0000, 32'h5, 32'hffff_0000, 32'h100, 1'b0);
        send_sphere(32'h1234_0000, 32'h5, 32'hffff_0000, 32'h200, 1'b1);
        // genuine merge, negative direction
        send_sphere(32'h0005_0000, 32'h0003_0000, 32'hfffe_0000, 32'h0001_0000, 1'b0);
        send_sphere(32'hfff0_0000, 32'h0002_0000, 32'h0007_0000, 32'h0002_0000, 1'b1);
        // opposite corners with full radii: radius saturates
        send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_fff0, 1'b0);
        send_sphere(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);
        // zero-radius points merging
        send_sphere(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_sphere(32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 1'b0);
        send_sphere(32'hffff_ffff, 32'h1, 32'hffff_ffff, 32'h0, 1'b1);
        drain_results();
    endtask

    task automatic test_random_runs(int n_items);
        int  sent;
        int  len;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                send_sphere(rand_word(), rand_word(), rand_word(),
                            $urandom_range(0, 7) == 0 ? $urandom : rand_word() >> 4,
                            k == len - 1);
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        // hold the receiver off while single-sphere runs keep coming
        hold_off_cycles = 3000;
        for (int k = 0; k < 6; k++)
            send_sphere($urandom, $urandom, $urandom, $urandom, 1'b1, 0);
        drain_results();
    endtask

    initial begin
        error_count     = 0;
        hold_off_cycles = 0;
        rand_stall_en   = 1'b0;
        hold_valid      = 1'b0;
        hold_x = '0; hold_y = '0; hold_z = '0; hold_r = '0;
        i_rst_n            <= 1'b0;
        sph_if.valid       <= 1'b0;
        sph_if.center_x    <= '0;
        sph_if.center_y    <= '0;
        sph_if.center_z    <= '0;
        sph_if.radius      <= '0;
        sph_if.last_sphere <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        rand_stall_en = 1'b1;
        test_random_runs(560);
        rand_stall_en = 1'b0;
        test_random_runs(560);

        drain_results();
        repeat (1000) @(posedge i_clk);
        if (error_count == 0 && expected_spheres.size() == 0) begin
            $display("bounding_sphere_merge_core verification clean");
        end else begin
            $display("bounding_sphere_merge_core verification failed");
        end
        $finish;
    end
endmodule
